FILE: src/matrix4x4_column_transform_core_assert.svh
// Assertion helpers shared by the transform core modules.
// Each macro builds one labeled concurrent assertion that is disabled while reset is held.
`ifndef MATRIX4X4_COLUMN_TRANSFORM_CORE_ASSERT_SVH
`define MATRIX4X4_COLUMN_TRANSFORM_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("transform core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MCCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("transform core assertion failed");

`endif

FILE: src/mcct_pkg.sv
package mcct_pkg;

	localparam int ELEM_W                = 32;
	localparam int PROD_W                = 2 * ELEM_W;
	// Four products summed need two guard bits above the product width.
	localparam int ACC_W                 = PROD_W + 2;
	localparam int NUM_ROWS              = 4;
	localparam int NUM_COLS              = 4;
	localparam int NUM_PAIRS             = 8;
	localparam int PAIR_W                = 2 * ELEM_W;
	localparam int PAIR_IDX_W            = $clog2(NUM_PAIRS);
	localparam int CFG_IDX_W             = 8;
	localparam int FRACTION_BITS_DEFAULT = 16;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [PAIR_W-1:0]        pair_t;

	localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	// One beat traveling down the chain: the mode, the input column (consumed from
	// element 0 as it moves) and the four running row sums.
	typedef struct packed {
		logic                  action;
		elem_t [NUM_ROWS-1:0]  b;
		acc_t  [NUM_ROWS-1:0]  acc;
	} beat_t;

endpackage

FILE: src/matrix4x4_column_transform_core.sv
// 4x4 matrix by column transform, signed fixed point with FRACTION_BITS fraction bits.
// The matrix is held column-major in eight 64-bit registers (cfg_index 0..7, element 2r in
// bits 31..0 and element 2r+1 in bits 63..32); reset loads the identity, and writes to an
// index of 8 or above are dropped. Each input beat carries one column; with action low the
// result is the matrix times that column, with action high in3 is replaced by one and out3
// is forced to zero (affine vertex transform). Sums are exact, floored by an arithmetic shift
// and clamped to 32 bits, with saturated set if any reported element clamped. The datapath
// is a row of four identical cells, one per matrix column, each with four 32x32 multipliers
// followed by the adders that extend the running row sums, then a shift-and-clamp output
// register. A new beat is taken every clock while out_ready is high; a beat passes two
// stages per cell and the output register, delayed only while out_ready is held low.
// Stalled stages absorb beats, so in_ready drops only once the output register and every
// cell stage are full; in_ready follows out_ready combinationally through the chain.
// Configuration may only be written while no beat is in flight.
module matrix4x4_column_transform_core #(
	parameter int FRACTION_BITS = mcct_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port
	input  logic                            cfg_we,
	input  logic [mcct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mcct_pkg::PAIR_W-1:0]     cfg_data,
	// Input column channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            action,
	input  mcct_pkg::elem_t                 in0,
	input  mcct_pkg::elem_t                 in1,
	input  mcct_pkg::elem_t                 in2,
	input  mcct_pkg::elem_t                 in3,
	// Result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output mcct_pkg::elem_t                 out0,
	output mcct_pkg::elem_t                 out1,
	output mcct_pkg::elem_t                 out2,
	output mcct_pkg::elem_t                 out3,
	output logic                            saturated
);
	import mcct_pkg::*;

	// Fixed-point one in the chosen format.
	localparam elem_t FIX_ONE = elem_t'(1) << FRACTION_BITS;

	pair_t                  coeff_q [NUM_PAIRS];
	elem_t [NUM_ROWS-1:0]   col_coef [NUM_COLS];
	logic  [NUM_COLS:0]     chain_valid;
	logic  [NUM_COLS:0]     chain_ready;
	beat_t [NUM_COLS:0]     chain_beat;
	elem_t [NUM_ROWS-1:0]   res;

	// Configuration registers. Reset gives the identity: elements 0, 5, 10 and 15.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PAIRS; i++) begin
				case (i)
					0, 5: begin
						coeff_q[i] <= {{ELEM_W{1'b0}}, FIX_ONE};
					end
					2, 7: begin
						coeff_q[i] <= {FIX_ONE, {ELEM_W{1'b0}}};
					end
					default: begin
						coeff_q[i] <= '0;
					end
				endcase
			end
		end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_PAIRS))) begin
			coeff_q[cfg_index[PAIR_IDX_W-1:0]] <= cfg_data;
		end
	end

	// Column c of the matrix occupies pairs 2c (rows 0, 1) and 2c+1 (rows 2, 3).
	always_comb begin
		for (int c = 0; c < NUM_COLS; c++) begin
			col_coef[c] = {coeff_q[2*c+1], coeff_q[2*c]};
		end
	end

	// The head of the chain takes the beat with zero sums; in vertex mode the fourth
	// column element is the fixed-point one.
	always_comb begin
		chain_beat[0].action = action;
		chain_beat[0].b      = {action ? FIX_ONE : in3, in2, in1, in0};
		chain_beat[0].acc    = '0;
	end

	assign chain_valid[0] = in_valid;
	assign in_ready       = chain_ready[0];

	for (genvar c = 0; c < NUM_COLS; c++) begin : g_cell
		mcct_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.coef      (col_coef[c]),
			.in_valid  (chain_valid[c]),
			.in_ready  (chain_ready[c]),
			.in_beat   (chain_beat[c]),
			.out_valid (chain_valid[c+1]),
			.out_ready (chain_ready[c+1]),
			.out_beat  (chain_beat[c+1])
		);
	end

	// Shift, clamp and hold the result until the downstream side takes it.
	mcct_out #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[NUM_COLS]),
		.in_ready  (chain_ready[NUM_COLS]),
		.in_beat   (chain_beat[NUM_COLS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res),
		.sat       (saturated)
	);

	assign out0 = res[0];
	assign out1 = res[1];
	assign out2 = res[2];
	assign out3 = res[3];

endmodule

FILE: src/mcct_cell.sv
`include "matrix4x4_column_transform_core_assert.svh"

module mcct_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mcct_pkg::elem_t [mcct_pkg::NUM_ROWS-1:0] coef,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  mcct_pkg::beat_t                        in_beat,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output mcct_pkg::beat_t                        out_beat
);
	import mcct_pkg::*;

	logic                   valid_s1;
	logic                   valid_s2;
	beat_t                  beat_s1;
	beat_t                  beat_s2;
	prod_t [NUM_ROWS-1:0]   prod_s1;
	prod_t [NUM_ROWS-1:0]   prod_d;
	beat_t                  next_s1;
	beat_t                  next_s2;
	logic                   take_s1;
	logic                   take_s2;

	assign take_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || take_s2;
	assign take_s1  = in_valid && in_ready;

	// The cell multiplies its matrix column by the leading column element and
	// hands the rest of the column one place down to the next cell.
	always_comb begin
		next_s1   = in_beat;
		next_s1.b = {elem_t'(0), in_beat.b[NUM_ROWS-1:1]};
		for (int r = 0; r < NUM_ROWS; r++) begin
			prod_d[r] = prod_t'($signed(coef[r])) * prod_t'($signed(in_beat.b[0]));
		end
	end

	always_comb begin
		next_s2 = beat_s1;
		for (int r = 0; r < NUM_ROWS; r++) begin
			next_s2.acc[r] = $signed(beat_s1.acc[r]) + acc_t'($signed(prod_s1[r]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (!valid_s2 || out_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			beat_s1 <= next_s1;
			prod_s1 <= prod_d;
		end
		if (take_s2) begin
			beat_s2 <= next_s2;
		end
	end

	assign out_valid = valid_s2;
	assign out_beat  = beat_s2;

	`MCCT_ASSERT_NEXT(a_sum_held, clk, arst_n, valid_s2 && !out_ready, valid_s2 && $stable(beat_s2))
	`MCCT_ASSERT_NEXT(a_prod_held, clk, arst_n, valid_s1 && !take_s2, valid_s1 && $stable(prod_s1))
	`MCCT_ASSERT_IMPLY(a_full_when_blocked, clk, arst_n, !in_ready, valid_s1 && valid_s2)

endmodule

FILE: src/mcct_out.sv
`include "matrix4x4_column_transform_core_assert.svh"

module mcct_out #(
	parameter int FRACTION_BITS = mcct_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  mcct_pkg::beat_t                         in_beat,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output mcct_pkg::elem_t [mcct_pkg::NUM_ROWS-1:0] res,
	output logic                                    sat
);
	import mcct_pkg::*;

	logic                   valid_q;
	logic                   vertex_q;
	elem_t [NUM_ROWS-1:0]   res_q;
	logic                   sat_q;
	acc_t  [NUM_ROWS-1:0]   shifted;
	logic  [NUM_ROWS-1:0]   over;
	elem_t [NUM_ROWS-1:0]   res_d;
	logic                   sat_d;
	logic                   take;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// Arithmetic shift gives the floor of the exact sum; the value fits in 32 bits
	// only when every bit above the result's sign bit copies it.
	always_comb begin
		sat_d = 1'b0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			shifted[r] = $signed(in_beat.acc[r]) >>> FRACTION_BITS;
			over[r]    = (|shifted[r][ACC_W-1:ELEM_W-1]) && !(&shifted[r][ACC_W-1:ELEM_W-1]);
			if (over[r]) begin
				res_d[r] = shifted[r][ACC_W-1] ? ELEM_MIN : ELEM_MAX;
			end else begin
				res_d[r] = shifted[r][ELEM_W-1:0];
			end
		end
		// A vertex has no w row: it reads as zero and never flags.
		if (in_beat.action) begin
			res_d[NUM_ROWS-1] = '0;
			over[NUM_ROWS-1]  = 1'b0;
		end
		sat_d = |over;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q    <= res_d;
			sat_q    <= sat_d;
			vertex_q <= in_beat.action;
		end
	end

	assign out_valid = valid_q;
	assign res       = res_q;
	assign sat       = sat_q;

	`MCCT_ASSERT_IMPLY(a_sat_at_bound, clk, arst_n, valid_q && sat_q, (res_q[0] == ELEM_MAX) || (res_q[0] == ELEM_MIN) || (res_q[1] == ELEM_MAX) || (res_q[1] == ELEM_MIN) || (res_q[2] == ELEM_MAX) || (res_q[2] == ELEM_MIN) || (res_q[3] == ELEM_MAX) || (res_q[3] == ELEM_MIN))
	`MCCT_ASSERT_IMPLY(a_vertex_w_zero, clk, arst_n, valid_q && vertex_q, res_q[NUM_ROWS-1] == '0)
	`MCCT_ASSERT_IMPLY(a_blocked_only_full, clk, arst_n, !in_ready, valid_q && !out_ready)

endmodule

FILE: test/matrix4x4_column_transform_core_test.sv
module matrix4x4_column_transform_core_test;

	import mcct_pkg::*;

	// The block runs at its default precision, so the testbench does too.
	localparam int FRAC_BITS = FRACTION_BITS_DEFAULT;

	// Values that the directed table refers to by name.
	localparam elem_t HI         = ELEM_MAX;
	localparam elem_t LO         = ELEM_MIN;
	localparam elem_t ZERO       = '0;
	localparam elem_t LSB        = elem_t'(1);
	localparam elem_t NEG        = '1;
	localparam elem_t ONE        = elem_t'(1 << FRAC_BITS);
	localparam elem_t LO_SCALED  = ELEM_MIN >>> FRAC_BITS;

	// Timing of the run. The settle pause outlasts a beat's trip across the
	// pipeline, so it guarantees the chain is empty.
	localparam int MAX_WAIT        = 17;
	localparam int PIPE_SETTLE     = 12;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int MAX_REPORTS     = 10;
	localparam int RANDOM_PHASES   = 9;
	localparam int ITEMS_PER_PHASE = 100;

	// Register indexes beyond the coefficient pairs, which the block must drop.
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_PAST = CFG_IDX_W'(NUM_PAIRS);
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_TOP  = '1;

	typedef enum logic {
		ACT_PRODUCT = 1'b0,
		ACT_VERTEX  = 1'b1
	} action_e;

	typedef enum logic [1:0] {
		STYLE_FULL,
		STYLE_SMALL,
		STYLE_EXTREME
	} value_style_e;

	// Matrix settings. The three random settings come last and in the same
	// order as the value styles, so a phase number maps straight onto them.
	typedef enum logic [3:0] {
		MAT_RESET,
		MAT_ALL_MAX,
		MAT_ALL_MIN,
		MAT_ZERO,
		MAT_W_ROW_MAX,
		MAT_FRACTIONAL,
		MAT_RANDOM_FULL,
		MAT_RANDOM_SMALL,
		MAT_RANDOM_EXTREME
	} matrix_sel_e;

	typedef struct packed {
		elem_t r0;
		elem_t r1;
		elem_t r2;
		elem_t r3;
		logic  sat;
	} column_result_t;

	typedef struct packed {
		matrix_sel_e    mat;
		action_e        act;
		elem_t          in0;
		elem_t          in1;
		elem_t          in2;
		elem_t          in3;
		bit             known;
		column_result_t want;
	} directed_row_t;

	localparam bit KNOWN   = 1'b1;
	localparam bit PREDICT = 1'b0;

	// Directed beats. Rows marked KNOWN carry a result that follows directly
	// from the matrix in force; the others are checked against the predictor.
	// A change of matrix between rows drains the pipeline and reloads it.
	localparam int NUM_DIRECTED = 24;
	localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		// Identity after reset: product columns pass through unchanged; vertex rows report w as zero.
		'{MAT_RESET, ACT_PRODUCT, ZERO, ZERO, ZERO, ZERO, KNOWN, '{ZERO, ZERO, ZERO, ZERO, 1'b0}},
		'{MAT_RESET, ACT_PRODUCT, HI, LO, HI, LO, KNOWN, '{HI, LO, HI, LO, 1'b0}},
		'{MAT_RESET, ACT_PRODUCT, LO, HI, LO, HI, KNOWN, '{LO, HI, LO, HI, 1'b0}},
		'{MAT_RESET, ACT_PRODUCT, NEG, NEG, NEG, NEG, KNOWN, '{NEG, NEG, NEG, NEG, 1'b0}},
		'{MAT_RESET, ACT_VERTEX, HI, LO, LSB, HI, KNOWN, '{HI, LO, LSB, ZERO, 1'b0}},
		'{MAT_RESET, ACT_VERTEX, NEG, NEG, NEG, LO, KNOWN, '{NEG, NEG, NEG, ZERO, 1'b0}},
		// Every coefficient at the positive bound: sums overflow both ways.
		'{MAT_ALL_MAX, ACT_PRODUCT, HI, HI, HI, HI, KNOWN, '{HI, HI, HI, HI, 1'b1}},
		'{MAT_ALL_MAX, ACT_PRODUCT, LO, LO, LO, LO, KNOWN, '{LO, LO, LO, LO, 1'b1}},
		'{MAT_ALL_MAX, ACT_PRODUCT, ZERO, ZERO, ZERO, ZERO, KNOWN, '{ZERO, ZERO, ZERO, ZERO, 1'b0}},
		// Only the implicit w contributes, landing exactly on the bound.
		'{MAT_ALL_MAX, ACT_VERTEX, ZERO, ZERO, ZERO, HI, KNOWN, '{HI, HI, HI, ZERO, 1'b0}},
		'{MAT_ALL_MAX, ACT_VERTEX, HI, HI, HI, LO, KNOWN, '{HI, HI, HI, ZERO, 1'b1}},
		// Every coefficient at the negative bound.
		'{MAT_ALL_MIN, ACT_PRODUCT, LO, LO, LO, LO, KNOWN, '{HI, HI, HI, HI, 1'b1}},
		'{MAT_ALL_MIN, ACT_PRODUCT, HI, HI, HI, HI, KNOWN, '{LO, LO, LO, LO, 1'b1}},
		'{MAT_ALL_MIN, ACT_VERTEX, ZERO, ZERO, ZERO, HI, KNOWN, '{LO, LO, LO, ZERO, 1'b0}},
		'{MAT_ALL_MIN, ACT_PRODUCT, LSB, ZERO, ZERO, ZERO, KNOWN,
			'{LO_SCALED, LO_SCALED, LO_SCALED, LO_SCALED, 1'b0}},
		// Identity in rows 0..2 and a huge fourth row: in vertex mode that row
		// is not reported and must not raise the saturation flag.
		'{MAT_W_ROW_MAX, ACT_VERTEX, HI, HI, HI, HI, KNOWN, '{HI, HI, HI, ZERO, 1'b0}},
		'{MAT_W_ROW_MAX, ACT_PRODUCT, HI, HI, HI, HI, KNOWN, '{HI, HI, HI, HI, 1'b1}},
		'{MAT_W_ROW_MAX, ACT_PRODUCT, ZERO, ZERO, ZERO, ONE, KNOWN, '{ZERO, ZERO, ZERO, HI, 1'b0}},
		// Fractional coefficients of both signs exercise the floor on the shift.
		'{MAT_FRACTIONAL, ACT_PRODUCT, LSB, LSB, LSB, LSB, PREDICT, '0},
		'{MAT_FRACTIONAL, ACT_PRODUCT, NEG, NEG, NEG, NEG, PREDICT, '0},
		'{MAT_FRACTIONAL, ACT_VERTEX, NEG, NEG, NEG, ZERO, PREDICT, '0},
		'{MAT_FRACTIONAL, ACT_PRODUCT, HI, LO, LO, HI, PREDICT, '0},
		// All-zero matrix.
		'{MAT_ZERO, ACT_PRODUCT, HI, LO, HI, LO, KNOWN, '{ZERO, ZERO, ZERO, ZERO, 1'b0}},
		'{MAT_ZERO, ACT_VERTEX, LO, HI, NEG, LSB, KNOWN, '{ZERO, ZERO, ZERO, ZERO, 1'b0}}
	};

	logic clk;
	logic arst_n = 1'b0;

	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [PAIR_W-1:0]    cfg_data  = '0;

	logic  in_valid = 1'b0;
	logic  in_ready;
	logic  action   = 1'b0;
	elem_t in0      = '0;
	elem_t in1      = '0;
	elem_t in2      = '0;
	elem_t in3      = '0;

	logic  out_valid;
	logic  out_ready = 1'b0;
	elem_t out0;
	elem_t out1;
	elem_t out2;
	elem_t out3;
	logic  saturated;

	// The testbench's own copy of the coefficient registers.
	pair_t coeff_pairs [NUM_PAIRS];

	// Results owed by the block, oldest first.
	column_result_t awaited_results [$];

	int mismatch_count = 0;

	// When set, the side concerned runs back to back for a while.
	bit sender_eager   = 1'b0;
	bit receiver_eager = 1'b0;

	matrix4x4_column_transform_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.in0       (in0),
		.in1       (in1),
		.in2       (in2),
		.in3       (in3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out0      (out0),
		.out1      (out1),
		.out2      (out2),
		.out3      (out3),
		.saturated (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Matrix times column. Each row sum is formed exactly at accumulator width,
	// floored by an arithmetic shift and then clamped to 32 bits. In vertex mode
	// the fourth input is one and the fourth row is neither reported nor allowed
	// to set the flag.
	function automatic column_result_t transform_column(action_e act, elem_t b0, elem_t b1,
			elem_t b2, elem_t b3);
		elem_t          col [NUM_COLS];
		elem_t          row_out [NUM_ROWS];
		elem_t          coeff;
		pair_t          pair;
		prod_t          term;
		acc_t           sum;
		logic           clamped;
		int             k;
		column_result_t res;
		col[0] = b0;
		col[1] = b1;
		col[2] = b2;
		col[3] = (act == ACT_VERTEX) ? ONE : b3;
		clamped = 1'b0;
		for (int r = 0; r < NUM_ROWS; r++) begin
			sum = '0;
			for (int c = 0; c < NUM_COLS; c++) begin
				// Column-major: element k sits at row k mod 4, column k div 4.
				k = r + NUM_ROWS * c;
				pair = coeff_pairs[k / 2];
				coeff = (k % 2 != 0) ? pair[PAIR_W-1:ELEM_W] : pair[ELEM_W-1:0];
				term = prod_t'(coeff) * prod_t'(col[c]);
				sum = sum + acc_t'(term);
			end
			sum = sum >>> FRAC_BITS;
			if (act == ACT_VERTEX && r == NUM_ROWS - 1) begin
				row_out[r] = ZERO;
			end else if (sum > acc_t'(ELEM_MAX)) begin
				row_out[r] = ELEM_MAX;
				clamped = 1'b1;
			end else if (sum < acc_t'(ELEM_MIN)) begin
				row_out[r] = ELEM_MIN;
				clamped = 1'b1;
			end else begin
				row_out[r] = sum[ELEM_W-1:0];
			end
		end
		res.r0 = row_out[0];
		res.r1 = row_out[1];
		res.r2 = row_out[2];
		res.r3 = row_out[3];
		res.sat = clamped;
		return res;
	endfunction

	// Random element. Small values stay near unity so that sums mostly land in
	// range; full values tend to saturate; extremes hit the corners.
	function automatic elem_t draw_value(value_style_e style);
		case (style)
			STYLE_FULL: begin
				return elem_t'($urandom);
			end
			STYLE_SMALL: begin
				return elem_t'(int'($urandom_range(0, 8 << FRAC_BITS)) - (4 << FRAC_BITS));
			end
			default: begin
				case ($urandom_range(0, 6))
					0: return ZERO;
					1: return HI;
					2: return LO;
					3: return ONE;
					4: return -ONE;
					5: return NEG;
					default: return LSB;
				endcase
			end
		endcase
	endfunction

	// One register write per clock. Out-of-range indexes leave the copy alone.
	task automatic write_coeff_pair(logic [CFG_IDX_W-1:0] index, pair_t data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		if (index < NUM_PAIRS)
			coeff_pairs[index] = data;
		@(posedge clk);
	endtask

	// Writes all eight pairs for the chosen matrix, then two writes at
	// indexes the block must ignore.
	task automatic load_matrix(matrix_sel_e sel);
		elem_t entry [2*NUM_PAIRS];
		for (int k = 0; k < 2 * NUM_PAIRS; k++) begin
			case (sel)
				MAT_ALL_MAX: begin
					entry[k] = HI;
				end
				MAT_ALL_MIN: begin
					entry[k] = LO;
				end
				MAT_ZERO: begin
					entry[k] = ZERO;
				end
				MAT_W_ROW_MAX: begin
					if (k % NUM_ROWS == NUM_ROWS - 1)
						entry[k] = HI;
					else
						entry[k] = (k % 5 == 0) ? ONE : ZERO;
				end
				MAT_FRACTIONAL: begin
					entry[k] = elem_t'(32'h0000_8001 + k * 32'h0001_1357);
					if (k % 2 != 0)
						entry[k] = -entry[k];
				end
				MAT_RANDOM_FULL: begin
					entry[k] = draw_value(STYLE_FULL);
				end
				MAT_RANDOM_SMALL: begin
					entry[k] = draw_value(STYLE_SMALL);
				end
				MAT_RANDOM_EXTREME: begin
					entry[k] = draw_value(STYLE_EXTREME);
				end
				default: begin
					entry[k] = (k % 5 == 0) ? ONE : ZERO;
				end
			endcase
		end
		for (int r = 0; r < NUM_PAIRS; r++)
			write_coeff_pair(CFG_IDX_W'(r), {entry[2*r+1], entry[2*r]});
		write_coeff_pair(CFG_INDEX_PAST, {$urandom, $urandom});
		write_coeff_pair(CFG_INDEX_TOP, {$urandom, $urandom});
		cfg_we <= 1'b0;
	endtask

	// Drops valid, waits for every owed result and then lets the pipeline run
	// dry, so the next register write sees an idle block.
	task automatic settle_pipeline();
		in_valid <= 1'b0;
		@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// Offers one column beat after a random gap and holds it until taken.
	// Ready is looked at on the falling edge, where everything has settled;
	// the beat then moves on the rising edge that follows. Entered and left
	// on a rising edge, with valid still high so back-to-back beats leave no
	// hole.
	task automatic send_column(action_e act, elem_t c0, elem_t c1, elem_t c2, elem_t c3,
			bit known, column_result_t want);
		int gap;
		gap = sender_eager ? 0 : $urandom_range(0, MAX_WAIT);
		if ($urandom_range(0, 39) == 0)
			sender_eager = !sender_eager;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		in0 <= c0;
		in1 <= c1;
		in2 <= c2;
		in3 <= c3;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		awaited_results.push_back(known ? want : transform_column(act, c0, c1, c2, c3));
		@(posedge clk);
	endtask

	// Result side: stalls a random number of cycles per beat, then takes the
	// next result and compares it with the oldest one owed.
	initial begin : result_sink
		int             stall;
		column_result_t got;
		column_result_t want;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = receiver_eager ? 0 : $urandom_range(0, MAX_WAIT);
			if ($urandom_range(0, 39) == 0)
				receiver_eager = !receiver_eager;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid)
				@(negedge clk);
			got = '{out0, out1, out2, out3, saturated};
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result beat: %h %h %h %h sat %b",
						got.r0, got.r1, got.r2, got.r3, got.sat);
			end else begin
				want = awaited_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("result mismatch: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
							want.r0, want.r1, want.r2, want.r3, want.sat,
							got.r0, got.r1, got.r2, got.r3, got.sat);
				end
			end
			@(posedge clk);
		end
	end

	// Ends the run if no beat moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[matrix4x4_column_transform_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		matrix_sel_e loaded;
		// Registers come out of reset holding the identity matrix.
		for (int r = 0; r < NUM_PAIRS; r++)
			coeff_pairs[r] = '0;
		coeff_pairs[0] = {ZERO, ONE};
		coeff_pairs[2] = {ONE, ZERO};
		coeff_pairs[5] = {ZERO, ONE};
		coeff_pairs[7] = {ONE, ZERO};
		loaded = MAT_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (DIRECTED_ROWS[i].mat != loaded) begin
				settle_pipeline();
				load_matrix(DIRECTED_ROWS[i].mat);
				loaded = DIRECTED_ROWS[i].mat;
			end
			send_column(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].in0, DIRECTED_ROWS[i].in1,
				DIRECTED_ROWS[i].in2, DIRECTED_ROWS[i].in3, DIRECTED_ROWS[i].known,
				DIRECTED_ROWS[i].want);
		end

		// Random phases, each under a freshly drawn matrix of rotating style.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			settle_pipeline();
			load_matrix(matrix_sel_e'(int'(MAT_RANDOM_FULL) + p % 3));
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_column(action_e'($urandom_range(0, 1)),
					draw_value(value_style_e'($urandom_range(0, 2))),
					draw_value(value_style_e'($urandom_range(0, 2))),
					draw_value(value_style_e'($urandom_range(0, 2))),
					draw_value(value_style_e'($urandom_range(0, 2))),
					PREDICT, '0);
		end

		settle_pipeline();
		if (mismatch_count == 0)
			$display("[matrix4x4_column_transform_core] OK");
		else
			$display("[matrix4x4_column_transform_core] ERROR");
		$finish;
	end

endmodule
